FILE: design/ssmt_pkg.sv
// Shared types and constants for the small set membership table.
// No dependencies; imported by ssmt_cell and small_set_membership_table.
`default_nettype none

package ssmt_pkg;

  localparam int unsigned OP_W           = 2;
  localparam int unsigned VALUE_W        = 16;
  localparam int unsigned COUNT_W        = 5;
  localparam int unsigned DEF_CAPACITY   = 16;
  localparam int unsigned DEF_ELEM_WIDTH = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } ssmt_op_e;

  // Per-cycle write controls broadcast to every cell.
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } ssmt_ctl_t;

endpackage

`default_nettype wire

FILE: design/ssmt_cell.sv
// One slot of the set: holds an element, compares it to the request and
// passes the running hit flag up the row. Depends on ssmt_pkg.
`default_nettype none

module ssmt_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned CNT_W      = ssmt_pkg::COUNT_W,
  parameter int unsigned ELEM_WIDTH = ssmt_pkg::DEF_ELEM_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire ssmt_pkg::ssmt_ctl_t    ctl_i,
  input  wire logic [CNT_W-1:0]       count_i,
  input  wire logic [ELEM_WIDTH-1:0]  elem_i,
  input  wire logic [ELEM_WIDTH-1:0]  nbr_i,
  input  wire logic                   hit_i,
  output logic                        hit_o,
  output logic [ELEM_WIDTH-1:0]       entry_o
);
  import ssmt_pkg::*;

  logic [ELEM_WIDTH-1:0] entry_q;
  logic                  valid;
  logic                  match;
  logic                  at_tail;

  assign valid   = CNT_W'(IDX) < count_i;
  assign match   = valid && (entry_q == elem_i);
  assign hit_o   = hit_i || match;
  assign at_tail = CNT_W'(IDX) == count_i;
  assign entry_o = entry_q;

  // On delete, every slot at or above the match pulls its upper neighbor.
  always_ff @(posedge clk_i) begin
    if (ctl_i.del_en && hit_o) begin
      entry_q <= nbr_i;
    end else if (ctl_i.ins_en && at_tail) begin
      entry_q <= elem_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/small_set_membership_table.sv
// Small set membership table: a row of cells holding a packed list of distinct elements,
// plus the fill count and result register. Depends on ssmt_pkg and ssmt_cell.
//
// Takes one request (insert, delete, query, clear) every clock cycle; busy_o
// never rises. The result is registered and appears on the result ports in the
// cycle after the request is accepted, marked by valid_o for that single cycle, and the
// receiver has no way to stall it. Membership is resolved in the same cycle
// by the hit flag rippling through all CAPACITY cells, so the row length
// sets the critical path. Delete closes the gap by shifting the upper cells
// down one slot in that cycle. Entries are not cleared at reset; only the
// fill count and the result valid flag are.
`default_nettype none

module small_set_membership_table #(
  parameter int unsigned CAPACITY   = ssmt_pkg::DEF_CAPACITY,
  parameter int unsigned ELEM_WIDTH = ssmt_pkg::DEF_ELEM_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [ssmt_pkg::OP_W-1:0]     op_i,
  input  wire logic [ssmt_pkg::VALUE_W-1:0]  value_i,
  output logic                               valid_o,
  output logic                               was_member_o,
  output logic [ssmt_pkg::COUNT_W-1:0]       count_o,
  output logic                               empty_res_o,
  output logic                               full_res_o,
  output logic                               rejected_o
);
  import ssmt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  valid_q;
  logic                  was_q, empty_q, full_q, rej_q;
  logic [COUNT_W-1:0]    cnt_res_q;
  logic                  rej_d;
  logic                  accept;
  logic                  member;
  logic                  full_now;
  logic [ELEM_WIDTH-1:0] elem;
  ssmt_op_e              op;
  ssmt_ctl_t             ctl;

  logic [CAPACITY:0]       hit;
  logic [ELEM_WIDTH-1:0]   entry [CAPACITY];

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign elem     = ELEM_WIDTH'(value_i);
  assign op       = ssmt_op_e'(op_i);
  assign full_now = count_q == CNT_W'(CAPACITY);
  assign hit[0]   = 1'b0;
  assign member   = hit[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_last
      assign nbr = entry[i];
    end else begin : g_mid
      assign nbr = entry[i+1];
    end
    ssmt_cell #(
      .IDX       (i),
      .CNT_W     (CNT_W),
      .ELEM_WIDTH(ELEM_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .count_i(count_q),
      .elem_i (elem),
      .nbr_i  (nbr),
      .hit_i  (hit[i]),
      .hit_o  (hit[i+1]),
      .entry_o(entry[i])
    );
  end

  always_comb begin
    count_d    = count_q;
    rej_d      = 1'b0;
    ctl.ins_en = 1'b0;
    ctl.del_en = 1'b0;
    if (accept) begin
      unique case (op)
        OP_INSERT: begin
          if (!member) begin
            if (full_now) begin
              rej_d = 1'b1;
            end else begin
              ctl.ins_en = 1'b1;
              count_d    = count_q + CNT_W'(1);
            end
          end
        end
        OP_DELETE: begin
          if (member) begin
            ctl.del_en = 1'b1;
            count_d    = count_q - CNT_W'(1);
          end
        end
        OP_QUERY: begin
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  // Result payload: capture on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      was_q     <= member;
      cnt_res_q <= COUNT_W'(count_d);
      empty_q   <= count_d == '0;
      full_q    <= count_d == CNT_W'(CAPACITY);
      rej_q     <= rej_d;
    end
  end

  assign valid_o      = valid_q;
  assign was_member_o = was_q;
  assign count_o      = cnt_res_q;
  assign empty_res_o  = empty_q;
  assign full_res_o   = full_q;
  assign rejected_o   = rej_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> count_o == COUNT_W'(count_q))
    else $error("reported count differs from fill count");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rejected_o |-> full_res_o && !was_member_o)
    else $error("reject without full set or with member present");

  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(empty_res_o && full_res_o))
    else $error("empty and full together");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OP_CLEAR |=> count_q == '0)
    else $error("clear left elements behind");
`endif

endmodule

`default_nettype wire

FILE: tb/small_set_membership_table_tb.sv
// Testbench for small_set_membership_table: directed and random set requests,
// checked against an in-bench model of the packed element list.
// Depends on ssmt_pkg and the small_set_membership_table RTL.
`timescale 1ns / 100ps

module small_set_membership_table_tb;
  import ssmt_pkg::*;

  localparam int unsigned CAPACITY       = DEF_CAPACITY;
  localparam int unsigned POOL_SIZE      = 22;
  localparam int unsigned RANDOM_PER_PH  = 100;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 4;

  typedef struct {
    ssmt_op_e         op;
    logic [VALUE_W-1:0] value;
    int unsigned      idle_pct;
  } set_req_t;

  typedef struct packed {
    logic               was_member;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    logic               full_res;
    logic               rejected;
  } set_status_t;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 start_i = 1'b0;
  logic [OP_W-1:0]      op_i    = '0;
  logic [VALUE_W-1:0]   value_i = '0;
  logic                 busy_o;
  logic                 valid_o;
  logic                 was_member_o;
  logic [COUNT_W-1:0]   count_o;
  logic                 empty_res_o;
  logic                 full_res_o;
  logic                 rejected_o;

  set_req_t     pending_reqs[$];
  set_status_t  status_due_q[$];

  // Model of the table contents
  logic [VALUE_W-1:0] set_elems[CAPACITY];
  int                 set_fill;

  int unsigned  fail_cnt;
  int unsigned  beats_in;
  int unsigned  beats_out;
  int unsigned  reject_cnt;
  int unsigned  full_cnt;
  int unsigned  quiet_cycles;
  set_req_t     nxt_req;
  set_status_t  pred;
  set_status_t  got;
  set_status_t  want;

  small_set_membership_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .value_i      (value_i),
    .valid_o      (valid_o),
    .was_member_o (was_member_o),
    .count_o      (count_o),
    .empty_res_o  (empty_res_o),
    .full_res_o   (full_res_o),
    .rejected_o   (rejected_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic set_status_t apply_set_request(ssmt_op_e op, logic [VALUE_W-1:0] v);
    set_status_t st;
    int          slot;
    slot = -1;
    for (int i = 0; i < set_fill; i++) begin
      if (slot < 0 && set_elems[i] == v) slot = i;
    end
    st.was_member = (slot >= 0);
    st.rejected   = 1'b0;
    case (op)
      OP_INSERT: begin
        if (slot < 0) begin
          if (set_fill >= CAPACITY) begin
            st.rejected = 1'b1;
          end else begin
            set_elems[set_fill] = v;
            set_fill++;
          end
        end
      end
      OP_DELETE: begin
        // close the gap left by the removed entry
        if (slot >= 0) begin
          for (int i = slot; i < set_fill - 1; i++) set_elems[i] = set_elems[i+1];
          set_fill--;
        end
      end
      OP_QUERY: begin
      end
      default: begin
        set_fill = 0;
      end
    endcase
    st.count     = COUNT_W'(set_fill);
    st.empty_res = (set_fill == 0);
    st.full_res  = (set_fill == CAPACITY);
    return st;
  endfunction

  task automatic add_req(ssmt_op_e op, logic [VALUE_W-1:0] v, int unsigned idle_pct);
    set_req_t r;
    r.op       = op;
    r.value    = v;
    r.idle_pct = idle_pct;
    pending_reqs.push_back(r);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Driver: predict on each accepted beat, then present the next request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      op_i    <= '0;
      value_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        pred = apply_set_request(ssmt_op_e'(op_i), value_i);
        if (pred.rejected) reject_cnt++;
        if (pred.full_res) full_cnt++;
        status_due_q.push_back(pred);
        beats_in++;
      end
      if (!start_i || !busy_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= pending_reqs[0].idle_pct) begin
          nxt_req = pending_reqs.pop_front();
          start_i <= 1'b1;
          op_i    <= nxt_req.op;
          value_i <= nxt_req.value;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (valid_o) begin
        got = {was_member_o, count_o, empty_res_o, full_res_o, rejected_o};
        if (status_due_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
          fail_cnt++;
        end else begin
          want = status_due_q.pop_front();
          check_field("was_member", want.was_member, got.was_member);
          check_field("count", want.count, got.count);
          check_field("empty_res", want.empty_res, got.empty_res);
          check_field("full_res", want.full_res, got.full_res);
          check_field("rejected", want.rejected, got.rejected);
        end
        beats_out++;
      end
      if (valid_o || (start_i && !busy_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [VALUE_W-1:0] pool[POOL_SIZE];
    int unsigned        idle_by_phase[4];
    int unsigned        r;
    ssmt_op_e           op;
    logic [VALUE_W-1:0] v;

    fail_cnt   = 0;
    beats_in   = 0;
    beats_out  = 0;
    reject_cnt = 0;
    full_cnt   = 0;
    set_fill   = 0;
    idle_by_phase = '{0, 73, 0, 13};

    // Directed: empty query, fill to capacity, full-table corner cases, clear
    add_req(OP_QUERY, 16'h0000, 0);
    add_req(OP_INSERT, 16'h0000, 0);
    add_req(OP_INSERT, 16'hFFFF, 0);
    for (int i = 0; i < CAPACITY - 2; i++) add_req(OP_INSERT, VALUE_W'(1) << i, 0);
    add_req(OP_INSERT, 16'h8000, 0);   // absent value on a full table
    add_req(OP_INSERT, 16'h0001, 0);   // duplicate on a full table
    add_req(OP_QUERY, 16'hFFFF, 0);
    add_req(OP_DELETE, 16'h0040, 0);   // middle slot, shifts upper entries
    add_req(OP_DELETE, 16'h1234, 0);   // absent
    add_req(OP_QUERY, 16'h0080, 0);
    add_req(OP_CLEAR, 16'h0000, 0);    // member before the clear
    add_req(OP_DELETE, 16'h0000, 0);

    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < POOL_SIZE; i++) pool[i] = VALUE_W'($urandom);
      pool[0] = 16'h0000;
      pool[1] = 16'hFFFF;
      for (int n = 0; n < RANDOM_PER_PH; n++) begin
        r = $urandom_range(99);
        if (r < 45)      op = OP_INSERT;
        else if (r < 70) op = OP_DELETE;
        else if (r < 97) op = OP_QUERY;
        else             op = OP_CLEAR;
        if ($urandom_range(9) == 0) v = VALUE_W'($urandom);
        else                        v = pool[$urandom_range(POOL_SIZE-1)];
        add_req(op, v, idle_by_phase[ph]);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || start_i || status_due_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("requests accepted: %0d, result beats checked: %0d", beats_in, beats_out);
    $display("inserts rejected on a full table: %0d, results reporting full: %0d",
             reject_cnt, full_cnt);
    if (fail_cnt == 0 && status_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ssmt_pkg.sv
design/ssmt_cell.sv
design/small_set_membership_table.sv
tb/small_set_membership_table_tb.sv
